### hw/rtl/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared constants for the box versus circle collision pipeline: default
// coordinate width and the hit cause codes.
// ----------------------------------------------------------------------------
package bcc_pkg;

    // default width of a signed screen coordinate
    localparam int COORD_BITS_DEF = 16;

    // hit cause codes
    localparam logic [1:0] CAUSE_NONE   = 2'd0;
    localparam logic [1:0] CAUSE_CORNER = 2'd1;
    localparam logic [1:0] CAUSE_CENTER = 2'd2;
    localparam logic [1:0] CAUSE_EDGE   = 2'd3;

endpackage

### hw/rtl/box_circle_collision.sv
// ----------------------------------------------------------------------------
// box_circle_collision
// Streaming collision test between an axis-aligned box and a circle, with a
// bounding box overlap gate and a cause code for the test that fired.
// ----------------------------------------------------------------------------
// Usage
//   Slave side (i_s_axis_*): one request per beat carries the box, the
//   circle center and radius, and the circle's bounding box.
//   Master side (o_m_axis_*): one result per request, hit flag and cause.
//   From an accepted request to o_m_axis_tvalid:
//   stage 1 forms the box and bounding box far edges, stage 2 the overlap
//   and containment compares and the corner distances, stage 3 squares the
//   distances and the radius, stage 4 (the output register) sums, compares
//   and picks the cause.
//   Throughput is one request per cycle while the receiver takes results. Each stage moves on when it is
//   empty or the stage after it moves, so bubbles are squeezed out while
//   the receiver holds i_m_axis_tready low; a stalled result holds its
//   data and nothing is dropped or repeated.
//   Synchronous active-low reset empties all stages; the block takes a
//   request in the first cycle after reset is released.
// ----------------------------------------------------------------------------
module box_circle_collision #(
    parameter int COORD_BITS = bcc_pkg::COORD_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // request channel
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // box_left, box_top, box_width, box_height, circle_x, circle_y, radius,
    // cbox_left, cbox_top, cbox_width, cbox_height, zero pad to bytes
    input  logic [((11*COORD_BITS-5+7)/8)*8-1:0] i_s_axis_tdata,
    // result channel
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // hit, hit_cause[1:0], zero pad
    output logic [7:0] o_m_axis_tdata
);
    import bcc_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int SW  = COORD_BITS - 1;      // size field width
    localparam int SQW = 2 * SW;              // square width
    localparam int SMW = SQW + 1;             // sum of two squares

    // field offsets in the request data
    localparam int OFF_BL = 0;
    localparam int OFF_BT = OFF_BL + C;
    localparam int OFF_BW = OFF_BT + C;
    localparam int OFF_BH = OFF_BW + SW;
    localparam int OFF_CX = OFF_BH + SW;
    localparam int OFF_CY = OFF_CX + C;
    localparam int OFF_R  = OFF_CY + C;
    localparam int OFF_QL = OFF_R + SW;
    localparam int OFF_QT = OFF_QL + C;
    localparam int OFF_QW = OFF_QT + C;
    localparam int OFF_QH = OFF_QW + SW;

    // magnitude of a - b, both one bit wider than a coordinate
    function automatic logic [C:0] abs_diff(input logic signed [C:0] a,
                                            input logic signed [C:0] b);
        logic signed [C+1:0] d;
        logic [C+1:0]        m;
        d = {a[C], a} - {b[C], b};
        m = d[C+1] ? (~d + 1'b1) : d;
        return m[C:0];
    endfunction

    // stage handshake
    logic r_vld1, r_vld2, r_vld3, r_vld4;
    logic en1, en2, en3, en4;

    assign en4 = !r_vld4 || i_m_axis_tready;
    assign en3 = !r_vld3 || en4;
    assign en2 = !r_vld2 || en3;
    assign en1 = !r_vld1 || en2;

    assign o_s_axis_tready = en1;

    // unpack request fields
    logic signed [C-1:0] in_bl, in_bt, in_cx, in_cy, in_ql, in_qt;
    logic [SW-1:0]       in_bw, in_bh, in_r, in_qw, in_qh;

    assign in_bl = i_s_axis_tdata[OFF_BL +: C];
    assign in_bt = i_s_axis_tdata[OFF_BT +: C];
    assign in_bw = i_s_axis_tdata[OFF_BW +: SW];
    assign in_bh = i_s_axis_tdata[OFF_BH +: SW];
    assign in_cx = i_s_axis_tdata[OFF_CX +: C];
    assign in_cy = i_s_axis_tdata[OFF_CY +: C];
    assign in_r  = i_s_axis_tdata[OFF_R  +: SW];
    assign in_ql = i_s_axis_tdata[OFF_QL +: C];
    assign in_qt = i_s_axis_tdata[OFF_QT +: C];
    assign in_qw = i_s_axis_tdata[OFF_QW +: SW];
    assign in_qh = i_s_axis_tdata[OFF_QH +: SW];

    // stage 1: far edges of both boxes
    logic signed [C:0] r_bx1, r_by1, r_bxe1, r_bye1;
    logic signed [C:0] r_qx1, r_qy1, r_qxe1, r_qye1;
    logic signed [C:0] r_cx1, r_cy1;
    logic [SW-1:0]     r_r1;
    logic              r_bw0_1, r_bh0_1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else if (en1) begin
            r_vld1 <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_bx1   <= {in_bl[C-1], in_bl};
            r_by1   <= {in_bt[C-1], in_bt};
            r_bxe1  <= {in_bl[C-1], in_bl} + {2'b00, in_bw};
            r_bye1  <= {in_bt[C-1], in_bt} + {2'b00, in_bh};
            r_qx1   <= {in_ql[C-1], in_ql};
            r_qy1   <= {in_qt[C-1], in_qt};
            r_qxe1  <= {in_ql[C-1], in_ql} + {2'b00, in_qw};
            r_qye1  <= {in_qt[C-1], in_qt} + {2'b00, in_qh};
            r_cx1   <= {in_cx[C-1], in_cx};
            r_cy1   <= {in_cy[C-1], in_cy};
            r_r1    <= in_r;
            r_bw0_1 <= (in_bw == '0);
            r_bh0_1 <= (in_bh == '0);
        end
    end

    // stage 2: overlap, containment, projection, corner distances
    logic [C:0]    dx0, dx1, dy0, dy1, rad_ext;
    logic          n_ovl2, n_ctr2, n_prj2;

    assign dx0     = abs_diff(r_bx1, r_cx1);
    assign dx1     = abs_diff(r_bxe1, r_cx1);
    assign dy0     = abs_diff(r_by1, r_cy1);
    assign dy1     = abs_diff(r_bye1, r_cy1);
    assign rad_ext = {2'b00, r_r1};

    assign n_ovl2 = !(r_qx1 >= r_bxe1 || r_qxe1 <= r_bx1 ||
                      r_qy1 >= r_bye1 || r_qye1 <= r_by1);
    assign n_ctr2 = r_cx1 >= r_bx1 && r_cx1 < r_bxe1 &&
                    r_cy1 >= r_by1 && r_cy1 < r_bye1;
    assign n_prj2 = (r_bh0_1 || (r_cy1 >= r_by1 && r_cy1 <= r_bye1)) ||
                    (r_bw0_1 || (r_cx1 >= r_bx1 && r_cx1 <= r_bxe1));

    logic [SW-1:0] r_dx0_2, r_dx1_2, r_dy0_2, r_dy1_2, r_r2;
    logic          r_dx0ok2, r_dx1ok2, r_dy0ok2, r_dy1ok2;
    logic          r_ovl2, r_ctr2, r_prj2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
        end else if (en2) begin
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_dx0_2  <= dx0[SW-1:0];
            r_dx1_2  <= dx1[SW-1:0];
            r_dy0_2  <= dy0[SW-1:0];
            r_dy1_2  <= dy1[SW-1:0];
            r_dx0ok2 <= (dx0 <= rad_ext);
            r_dx1ok2 <= (dx1 <= rad_ext);
            r_dy0ok2 <= (dy0 <= rad_ext);
            r_dy1ok2 <= (dy1 <= rad_ext);
            r_r2     <= r_r1;
            r_ovl2   <= n_ovl2;
            r_ctr2   <= n_ctr2;
            r_prj2   <= n_prj2;
        end
    end

    // stage 3: squares of distances and radius
    logic [SQW-1:0] sq_x0, sq_x1, sq_y0, sq_y1, sq_r;

    assign sq_x0 = SQW'(r_dx0_2) * SQW'(r_dx0_2);
    assign sq_x1 = SQW'(r_dx1_2) * SQW'(r_dx1_2);
    assign sq_y0 = SQW'(r_dy0_2) * SQW'(r_dy0_2);
    assign sq_y1 = SQW'(r_dy1_2) * SQW'(r_dy1_2);
    assign sq_r  = SQW'(r_r2) * SQW'(r_r2);

    logic [SQW-1:0] r_sqx0_3, r_sqx1_3, r_sqy0_3, r_sqy1_3, r_sqr3;
    logic           r_dx0ok3, r_dx1ok3, r_dy0ok3, r_dy1ok3;
    logic           r_ovl3, r_ctr3, r_prj3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
        end else if (en3) begin
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_sqx0_3 <= sq_x0;
            r_sqx1_3 <= sq_x1;
            r_sqy0_3 <= sq_y0;
            r_sqy1_3 <= sq_y1;
            r_sqr3   <= sq_r;
            r_dx0ok3 <= r_dx0ok2;
            r_dx1ok3 <= r_dx1ok2;
            r_dy0ok3 <= r_dy0ok2;
            r_dy1ok3 <= r_dy1ok2;
            r_ovl3   <= r_ovl2;
            r_ctr3   <= r_ctr2;
            r_prj3   <= r_prj2;
        end
    end

    // stage 4: corner tests and cause selection
    logic [SMW-1:0] sum00, sum01, sum10, sum11, rsq_ext;
    logic           corner;
    logic [1:0]     n_cause;

    assign sum00   = {1'b0, r_sqx0_3} + {1'b0, r_sqy0_3};
    assign sum01   = {1'b0, r_sqx0_3} + {1'b0, r_sqy1_3};
    assign sum10   = {1'b0, r_sqx1_3} + {1'b0, r_sqy0_3};
    assign sum11   = {1'b0, r_sqx1_3} + {1'b0, r_sqy1_3};
    assign rsq_ext = {1'b0, r_sqr3};

    assign corner = (r_dx0ok3 && r_dy0ok3 && sum00 <= rsq_ext) ||
                    (r_dx0ok3 && r_dy1ok3 && sum01 <= rsq_ext) ||
                    (r_dx1ok3 && r_dy0ok3 && sum10 <= rsq_ext) ||
                    (r_dx1ok3 && r_dy1ok3 && sum11 <= rsq_ext);

    always_comb begin
        if (!r_ovl3) begin
            n_cause = CAUSE_NONE;
        end else if (corner) begin
            n_cause = CAUSE_CORNER;
        end else if (r_ctr3) begin
            n_cause = CAUSE_CENTER;
        end else if (r_prj3) begin
            n_cause = CAUSE_EDGE;
        end else begin
            n_cause = CAUSE_NONE;
        end
    end

    logic       r_hit4;
    logic [1:0] r_cause4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld4 <= 1'b0;
        end else if (en4) begin
            r_vld4 <= r_vld3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_hit4   <= (n_cause != CAUSE_NONE);
            r_cause4 <= n_cause;
        end
    end

    assign o_m_axis_tvalid = r_vld4;
    assign o_m_axis_tdata  = {5'b00000, r_cause4, r_hit4};

    // hit flag agrees with the cause code
    a_hit_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld4 |-> (r_hit4 == (r_cause4 != CAUSE_NONE)))
        else $error("hit flag disagrees with cause");

    // an empty output stage never blocks the request side
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld4 |-> o_s_axis_tready)
        else $error("request side stalled with empty output");

    // an accepted request lands in stage 1
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld1)
        else $error("accepted request lost");

    // no overlap never reports a hit
    a_no_ovl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld3 && en4 && !r_ovl3) |=> (r_cause4 == CAUSE_NONE))
        else $error("hit without box overlap");

endmodule

### tb/box_circle_collision_tb.sv
// ----------------------------------------------------------------------------
// box_circle_collision_tb
// Self-checking bench for the box versus circle collision pipeline. A short
// table of hand-picked requests covers the field extremes, every hit cause
// and the zero-size corner cases. It is followed by randomized requests,
// mostly circles with their bounding boxes and nearby boxes, plus some raw
// noise. Each request is judged by an in-bench predictor unless its table
// row fixes the cause. Results are compared field by field, in order, while
// both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module box_circle_collision_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import bcc_pkg::*;

    localparam int CB       = COORD_BITS_DEF;
    localparam int TDW      = ((11*CB-5+7)/8)*8;
    localparam int N_DIR    = 20;
    localparam int N_RAND   = 1130;
    localparam int BY_MODEL = -1;
    localparam int LIMIT    = 600000;
    localparam int MAX_SIZE = (1 << (CB-1)) - 1;

    // one collision query, first field in the lowest bits
    typedef struct packed {
        logic [CB-2:0] cbox_height;
        logic [CB-2:0] cbox_width;
        logic [CB-1:0] cbox_top;
        logic [CB-1:0] cbox_left;
        logic [CB-2:0] radius;
        logic [CB-1:0] circle_y;
        logic [CB-1:0] circle_x;
        logic [CB-2:0] box_height;
        logic [CB-2:0] box_width;
        logic [CB-1:0] box_top;
        logic [CB-1:0] box_left;
    } query_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] cause;
    } outcome_t;

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           i_s_axis_tvalid;
    logic           o_s_axis_tready;
    logic [TDW-1:0] i_s_axis_tdata;   // box_left .. cbox_height, zero pad
    logic           o_m_axis_tvalid;
    logic           i_m_axis_tready;
    logic [7:0]     o_m_axis_tdata;   // hit, hit_cause[1:0], zero pad

    outcome_t outcome_on_bus;
    outcome_t outcomes_due[$];
    int       n_errors = 0;
    int       n_accepted = 0;
    int       n_results = 0;
    int       cause_tally[4] = '{0, 0, 0, 0};
    int       cycles = 0;
    int       snk_hold = 0;

    // directed requests: box, circle, bounding box, then the expected cause
    // or BY_MODEL where the predictor decides
    int dir_tab [0:N_DIR-1][0:11] = '{
        // everything zero, bounding box has no area
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, int'(CAUSE_NONE)},
        // all fields at their maximum
        '{32767, 32767, 32767, 32767, 32767, 32767, 32767,
          32767, 32767, 32767, 32767, BY_MODEL},
        // zero-width bounding box at the minimum corner
        '{-32768, -32768, 32767, 32767, -32768, -32768, 32767,
          -32768, -32768, 0, 32767, int'(CAUSE_NONE)},
        // zero radius circle sitting on a corner
        '{-32768, -32768, 32767, 32767, -32768, -32768, 0,
          -32768, -32768, 1, 1, BY_MODEL},
        // disjoint boxes
        '{0, 0, 10, 10, 100, 100, 10, 90, 90, 20, 20, int'(CAUSE_NONE)},
        // boxes only touching along an edge
        '{0, 0, 10, 10, 15, 5, 5, 10, 0, 10, 10, int'(CAUSE_NONE)},
        // corner exactly on the circle
        '{3, 4, 10, 10, 0, 0, 5, -5, -5, 10, 10, BY_MODEL},
        // corner just outside the circle
        '{4, 4, 10, 10, 0, 0, 5, -5, -5, 10, 10, BY_MODEL},
        // far corner on one axis, center level with the box
        '{6, 0, 10, 10, 0, 5, 5, -5, 0, 10, 10, BY_MODEL},
        // center inside the box
        '{0, 0, 100, 100, 50, 50, 10, 40, 40, 20, 20, BY_MODEL},
        // center on the right edge, which is outside the half-open box
        '{0, 0, 100, 100, 100, 50, 10, 90, 40, 20, 20, BY_MODEL},
        // center on the bottom edge
        '{0, 0, 100, 100, 50, 100, 10, 40, 90, 20, 20, BY_MODEL},
        // zero-height box
        '{0, 50, 100, 0, 500, 500, 3, 0, 40, 20, 20, BY_MODEL},
        // zero-width box
        '{50, 0, 0, 100, 500, 500, 3, 40, 0, 20, 20, BY_MODEL},
        // point box at a zero radius center
        '{0, 0, 0, 0, 0, 0, 0, -1, -1, 2, 2, BY_MODEL},
        // corners farther than the radius on every axis
        '{-32768, -32768, 32767, 32767, 32767, 32767, 32767,
          -32768, -32768, 32767, 32767, BY_MODEL},
        // huge radius reaching a corner
        '{-100, -100, 50, 50, -200, -200, 32767,
          -32768, -32768, 32767, 32767, BY_MODEL},
        // near a corner but outside, no projection
        '{0, 0, 100, 100, -5, -5, 3, -8, -8, 6, 6, BY_MODEL},
        // mixed extremes
        '{-20000, 12345, 32767, 1, 30000, -31000, 32767,
          -30000, -32768, 32767, 32767, BY_MODEL},
        '{32767, -32768, 0, 32767, -1, 0, 1, 32766, -1, 2, 2, BY_MODEL}
    };

    box_circle_collision #(.COORD_BITS(CB)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // corner test: per-axis distance first, squares only when both are close
    function automatic bit corner_inside(longint px, longint py, longint cx, longint cy,
                                         longint r);
        longint dx;
        longint dy;
        dx = (px >= cx) ? px - cx : cx - px;
        dy = (py >= cy) ? py - cy : cy - py;
        if (dx > r || dy > r) return 1'b0;
        return dx * dx + dy * dy <= r * r;
    endfunction

    // point on a closed span, a zero-length span always matches
    function automatic bit on_span(longint c, longint a, longint len);
        if (len == 0) return 1'b1;
        return c >= a && c <= a + len;
    endfunction

    // predicted hit and cause for one query
    function automatic outcome_t judge_collision(query_t q);
        longint   bx, by, bw, bh, cx, cy, r, qx, qy, qw, qh;
        outcome_t res;
        bx = longint'($signed(q.box_left));
        by = longint'($signed(q.box_top));
        bw = longint'(q.box_width);
        bh = longint'(q.box_height);
        cx = longint'($signed(q.circle_x));
        cy = longint'($signed(q.circle_y));
        r  = longint'(q.radius);
        qx = longint'($signed(q.cbox_left));
        qy = longint'($signed(q.cbox_top));
        qw = longint'(q.cbox_width);
        qh = longint'(q.cbox_height);
        res.cause = CAUSE_NONE;
        if (!(qx >= bx + bw || qx + qw <= bx || qy >= by + bh || qy + qh <= by)) begin
            if (corner_inside(bx, by, cx, cy, r) || corner_inside(bx, by + bh, cx, cy, r) ||
                corner_inside(bx + bw, by, cx, cy, r) ||
                corner_inside(bx + bw, by + bh, cx, cy, r))
                res.cause = CAUSE_CORNER;
            else if (cx >= bx && cx < bx + bw && cy >= by && cy < by + bh)
                res.cause = CAUSE_CENTER;
            else if (on_span(cy, by, bh) || on_span(cx, bx, bw))
                res.cause = CAUSE_EDGE;
        end
        res.hit = (res.cause != CAUSE_NONE);
        return res;
    endfunction

    function automatic query_t build_query(int bx, int by, int bw, int bh, int cx, int cy,
                                           int r, int qx, int qy, int qw, int qh);
        query_t q;
        q.box_left    = CB'(bx);
        q.box_top     = CB'(by);
        q.box_width   = (CB-1)'(bw);
        q.box_height  = (CB-1)'(bh);
        q.circle_x    = CB'(cx);
        q.circle_y    = CB'(cy);
        q.radius      = (CB-1)'(r);
        q.cbox_left   = CB'(qx);
        q.cbox_top    = CB'(qy);
        q.cbox_width  = (CB-1)'(qw);
        q.cbox_height = (CB-1)'(qh);
        return q;
    endfunction

    function automatic int sgn_range(int m);
        return int'($urandom_range(0, 2 * m)) - m;
    endfunction

    function automatic int clip_size(int v);
        return (v < 0) ? 0 : ((v > MAX_SIZE) ? MAX_SIZE : v);
    endfunction

    // random query: mostly a circle, its bounding box and a box nearby
    function automatic query_t rand_query();
        query_t          q;
        logic [6*32-1:0] raw;
        int     pick, lim, cx, cy, r, bw, bh, bx, by, qx, qy, qw, qh;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            q   = raw[$bits(query_t)-1:0];
            return q;
        end
        lim = (pick < 30) ? 16000 : ((pick < 60) ? 2000 : 200);
        r   = $urandom_range(0, lim);
        cx  = sgn_range(16000);
        cy  = sgn_range(16000);
        bw  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 2 * lim);
        bh  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 2 * lim);
        bx  = cx + sgn_range(bw + 2 * r + 2) - bw / 2;
        by  = cy + sgn_range(bh + 2 * r + 2) - bh / 2;
        qx  = cx - r;
        qy  = cy - r;
        qw  = clip_size(2 * r);
        qh  = clip_size(2 * r);
        // perturbed or degenerate bounding box now and then
        if ($urandom_range(0, 99) < 15) begin
            qx = qx + sgn_range(3);
            qy = qy + sgn_range(3);
            qw = clip_size(qw + sgn_range(3));
            qh = clip_size(qh + sgn_range(3));
        end
        if ($urandom_range(0, 99) < 4) qw = 0;
        if ($urandom_range(0, 99) < 4) qh = 0;
        return build_query(bx, by, clip_size(bw), clip_size(bh), cx, cy, r, qx, qy, qw, qh);
    endfunction

    // idle length: mostly none or short, sometimes long
    function automatic int pick_idle();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // offer one request and hold it until it is taken
    task automatic send_query(input query_t q, input outcome_t want, input bit steady);
        int gap;
        gap = steady ? 0 : pick_idle();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= TDW'(q);
        outcome_on_bus  <= want;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    // receiver back-pressure, with steady stretches
    always @(posedge i_clk) begin
        if (snk_hold > 0) begin
            snk_hold        <= snk_hold - 1;
            i_m_axis_tready <= 1'b0;
        end else if ((cycles / 1000) % 4 != 3 && $urandom_range(0, 99) < 25) begin
            snk_hold        <= pick_idle();
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // request tracking and result checking
    always @(posedge i_clk) begin : result_check
        outcome_t   want;
        logic       got_hit;
        logic [1:0] got_cause;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            outcomes_due.push_back(outcome_on_bus);
            n_accepted++;
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_hit   = o_m_axis_tdata[0];
            got_cause = o_m_axis_tdata[2:1];
            n_results++;
            cause_tally[got_cause]++;
            if (outcomes_due.size() == 0) begin
                n_errors++;
                $display("%0t: result with no request pending: hit=%0d cause=%0d",
                         $time, got_hit, got_cause);
            end else begin
                want = outcomes_due.pop_front();
                if (got_hit !== want.hit) begin
                    n_errors++;
                    $display("%0t: result %0d hit: expected %0d, actual %0d",
                             $time, n_results, want.hit, got_hit);
                end
                if (got_cause !== want.cause) begin
                    n_errors++;
                    $display("%0t: result %0d hit_cause: expected %0d, actual %0d",
                             $time, n_results, want.cause, got_cause);
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, outcomes_due.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        query_t   q;
        outcome_t want;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        outcome_on_bus  = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIR + N_RAND; i++) begin
            if (i < N_DIR) begin
                q = build_query(dir_tab[i][0], dir_tab[i][1], dir_tab[i][2], dir_tab[i][3],
                                dir_tab[i][4], dir_tab[i][5], dir_tab[i][6], dir_tab[i][7],
                                dir_tab[i][8], dir_tab[i][9], dir_tab[i][10]);
                want = judge_collision(q);
                if (dir_tab[i][11] != BY_MODEL) begin
                    want.cause = 2'(dir_tab[i][11]);
                    want.hit   = (want.cause != CAUSE_NONE);
                end
            end else begin
                q    = rand_query();
                want = judge_collision(q);
            end
            send_query(q, want, (i / 128) % 3 == 2);
        end
        i_s_axis_tvalid <= 1'b0;

        // drain, then keep watching for stray results
        @(posedge i_clk);
        while (outcomes_due.size() > 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (outcomes_due.size() != 0) begin
            n_errors++;
            $display("%0t: %0d expected results never arrived", $time, outcomes_due.size());
        end

        $display("run covered %0d requests (%0d table, %0d random) and %0d results",
                 n_accepted, N_DIR, N_RAND, n_results);
        $display("results by cause: none %0d, corner %0d, center %0d, edge %0d",
                 cause_tally[CAUSE_NONE], cause_tally[CAUSE_CORNER],
                 cause_tally[CAUSE_CENTER], cause_tally[CAUSE_EDGE]);
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### box_circle_collision.f
hw/rtl/bcc_pkg.sv
hw/rtl/box_circle_collision.sv
tb/box_circle_collision_tb.sv
